// File: sv/bb3_pkg.sv
// shared types, constants and reciprocal table for the 3x3 rgb box blur
package bb3_pkg;

  localparam int CH_W        = 8;
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int ENTRY_W     = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_W    = 13;

  localparam logic [CFG_IDX_W-1:0]   REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]   REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET      = 11'd640;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET     = 13'd480;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_LIMIT     = 13'd4096;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pix_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } sums_t;

  typedef struct packed {
    logic [2:0] col;
    logic [2:0] row;
  } mask_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_OUT
  } state_t;

  function automatic logic [1:0] count3(input logic [2:0] v);
    count3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
  endfunction

  // ceil(2^16 / n), exact floor for sums up to nine full-scale pixels
  function automatic logic [RECIP_W-1:0] recip_of(input mask_t m);
    logic [3:0] n;
    n = {2'b00, count3(m.col)} * {2'b00, count3(m.row)};
    unique case (n)
      4'd2:    recip_of = 17'd32768;
      4'd3:    recip_of = 17'd21846;
      4'd4:    recip_of = 17'd16384;
      4'd6:    recip_of = 17'd10923;
      4'd9:    recip_of = 17'd7282;
      default: recip_of = 17'd65536;
    endcase
  endfunction

endpackage

// File: sv/bb3_line_store.sv
// two-row line store, one synchronous memory with registered read
module bb3_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [bb3_pkg::ENTRY_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [bb3_pkg::ENTRY_W-1:0] wr_data
);
  import bb3_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/bb3_window.sv
// 3x3 pixel window and masked per-channel sums
module bb3_window (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clear,
  input  logic           shift_en,
  input  bb3_pkg::pix_t  up2,
  input  bb3_pkg::pix_t  up1,
  input  bb3_pkg::pix_t  pix,
  input  logic           sum_en,
  input  bb3_pkg::mask_t mask,
  output bb3_pkg::sums_t sums
);
  import bb3_pkg::*;

  pix_t  win_r [9];
  sums_t sums_r;
  sums_t sums_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (shift_en) begin
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= win_r[k+3];
      end
      win_r[6] <= up2;
      win_r[7] <= up1;
      win_r[8] <= pix;
    end
  end

  always_comb begin
    sums_nxt = '0;
    for (int k = 0; k < 9; k++) begin
      if (mask.col[k/3] && mask.row[k%3]) begin
        sums_nxt.r = sums_nxt.r + SUM_W'(win_r[k].r);
        sums_nxt.g = sums_nxt.g + SUM_W'(win_r[k].g);
        sums_nxt.b = sums_nxt.b + SUM_W'(win_r[k].b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sums_r <= sums_nxt;
    end
  end

  assign sums = sums_r;

endmodule

// File: sv/bb3_divide.sv
// divide channel sums by the neighbor count through a reciprocal multiply
module bb3_divide (
  input  bb3_pkg::sums_t               sums,
  input  logic [bb3_pkg::RECIP_W-1:0]  rcp,
  output bb3_pkg::pix_t                quot
);
  import bb3_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [PROD_W-1:0] prod_r_w;
  logic [PROD_W-1:0] prod_g_w;
  logic [PROD_W-1:0] prod_b_w;

  assign prod_r_w = PROD_W'(sums.r) * PROD_W'(rcp);
  assign prod_g_w = PROD_W'(sums.g) * PROD_W'(rcp);
  assign prod_b_w = PROD_W'(sums.b) * PROD_W'(rcp);

  assign quot.r = prod_r_w[RECIP_SHIFT +: CH_W];
  assign quot.g = prod_g_w[RECIP_SHIFT +: CH_W];
  assign quot.b = prod_b_w[RECIP_SHIFT +: CH_W];

endmodule

// File: sv/box_blur_3x3_rgb.sv
// top level of the streaming 3x3 rgb box blur
// a sequencer walks each item through line store read, window update and write-back,
//   sum, and divide; a new input is taken only once it is back in idle, and the
//   divide step holds while an earlier result still waits for out_ready
// items with no result skip sum and divide; the line store needs no clearing pass
// reset (synchronous, active low) restores 640x480 and restarts the frame
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [7:0]                     in_red_in,
  input  logic [7:0]                     in_green_in,
  input  logic [7:0]                     in_blue_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red_out,
  output logic [7:0]                     out_green_out,
  output logic [7:0]                     out_blue_out,
  output logic                           out_frame_end,
  input  logic                           cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bb3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  state_t state_r;
  state_t state_nxt;

  logic [WIDTH_REG_W-1:0] width_r;
  logic [HEIGHT_W-1:0]    height_r;
  logic [AW-1:0]          ic_r;
  logic [HEIGHT_W-1:0]    ir_r;
  pix_t                   pix_r;
  mask_t                  mask_r;
  logic [RECIP_W-1:0]     recip_r;
  logic                   last_r;
  logic                   out_valid_r;
  pix_t                   out_pix_r;
  logic                   out_end_r;

  logic [CW-1:0]       eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [AW-1:0]       ic_use;
  logic [CW-1:0]       ic_inc;
  logic                wrap;
  logic [AW-1:0]       ic_next;
  logic [HEIGHT_W-1:0] ir_next;
  logic [AW-1:0]       cc;
  logic [CW-1:0]       cc_ext;
  logic [HEIGHT_W:0]   cr;
  logic [HEIGHT_W-1:0] crow;
  logic                cr_ok;
  mask_t               mask_w;
  logic                last_w;

  logic                cfg_hit;
  logic                in_xfer;
  logic                mem_rd;
  logic                mem_wr;
  logic                win_shift;
  logic                sum_en;
  logic                out_load;

  logic [ENTRY_W-1:0]  rd_data;
  pix_t                up2;
  pix_t                up1;
  sums_t               sums;
  pix_t                quot;

  assign cfg_hit = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
  assign in_xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_data[WIDTH_REG_W-1:0];
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        height_r <= cfg_data[HEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    priority if (width_r == '0) begin
      eff_w = CW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(width_r);
    end
    priority if (height_r == '0) begin
      eff_h = HEIGHT_W'(1);
    end else if (height_r > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_LIMIT;
    end else begin
      eff_h = height_r;
    end
  end

  // stream position and the centre it releases
  always_comb begin
    ic_use  = (CW'(ic_r) >= eff_w) ? '0 : ic_r;
    ic_inc  = CW'(ic_use) + CW'(1);
    wrap    = ic_inc >= eff_w;
    ic_next = wrap ? '0 : AW'(ic_inc);
    ir_next = (wrap && ir_r != '1) ? ir_r + HEIGHT_W'(1) : ir_r;
    if (ic_use != '0) begin
      cc = ic_use - AW'(1);
      cr = {1'b0, ir_r} - (HEIGHT_W+1)'(1);
    end else begin
      cc = AW'(eff_w - CW'(1));
      cr = {1'b0, ir_r} - (HEIGHT_W+1)'(2);
    end
    cc_ext       = CW'(cc);
    crow         = cr[HEIGHT_W-1:0];
    cr_ok        = !cr[HEIGHT_W] && (crow < eff_h);
    mask_w.col   = {(cc_ext + CW'(1)) < eff_w, 1'b1, cc != '0};
    mask_w.row   = {({1'b0, crow} + (HEIGHT_W+1)'(1)) < {1'b0, eff_h}, 1'b1, crow != '0};
    last_w       = (({1'b0, crow} + (HEIGHT_W+1)'(1)) == {1'b0, eff_h})
                   && ((cc_ext + CW'(1)) == eff_w);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = cr_ok ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    mem_rd    = in_valid && (state_r == S_IDLE);
    mem_wr    = (state_r == S_READ);
    win_shift = (state_r == S_READ);
    sum_en    = (state_r == S_SUM);
    out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      ic_r <= '0;
      ir_r <= '0;
    end else if (state_r == S_READ) begin
      if (cr_ok && last_w) begin
        ic_r <= '0;
        ir_r <= '0;
      end else begin
        ic_r <= ic_next;
        ir_r <= ir_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_r <= in_mode ? '0 : {in_red_in, in_green_in, in_blue_in};
    end
    if (state_r == S_READ) begin
      mask_r  <= mask_w;
      recip_r <= recip_of(mask_w);
      last_r  <= last_w;
    end
  end

  assign up2 = rd_data[ENTRY_W-1:ENTRY_W/2];
  assign up1 = rd_data[ENTRY_W/2-1:0];

  bb3_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (mem_rd),
    .rd_addr (ic_use),
    .rd_data (rd_data),
    .wr_en   (mem_wr),
    .wr_addr (ic_use),
    .wr_data ({up1, pix_r})
  );

  bb3_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cfg_hit),
    .shift_en (win_shift),
    .up2      (up2),
    .up1      (up1),
    .pix      (pix_r),
    .sum_en   (sum_en),
    .mask     (mask_r),
    .sums     (sums)
  );

  bb3_divide u_divide (
    .sums (sums),
    .rcp  (recip_r),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r <= quot;
      out_end_r <= last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_pix_r.r;
  assign out_green_out = out_pix_r.g;
  assign out_blue_out  = out_pix_r.b;
  assign out_frame_end = out_end_r;

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_READ))
    else $error("transfer did not start a line store read");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd && mem_wr))
    else $error("line store read and write in the same cycle");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && cr_ok && last_w) |=> (ic_r == '0 && ir_r == '0))
    else $error("position not cleared after last pixel of frame");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> (state_r == S_OUT && out_valid_r))
    else $error("pending result dropped while output stalled");

endmodule
